/* hw/rtl/mss_pkg.sv */
package mss_pkg;

	typedef enum logic [2:0] {
		OP_START_ONESHOT  = 3'd0,
		OP_START_PERIODIC = 3'd1,
		OP_STOP           = 3'd2,
		OP_RESTART        = 3'd3,
		OP_TICK           = 3'd4
	} op_t;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] handle;
		logic [31:0] seconds;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic        ok;
		logic [15:0] fired_handle;
		logic [3:0]  slot_index;
		logic        last;
	} rsp_t;

	// what the head unit found in the slot now passing through it
	typedef struct packed {
		logic match;
		logic expire;
	} head_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

endpackage

/* hw/rtl/mss_cell.sv */
module mss_cell #(
	parameter int HANDLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic [HANDLE_BITS-1:0] owner_d,
	input  logic [31:0]            period_d,
	input  logic [31:0]            count_d,
	input  logic                   periodic_d,
	output logic [HANDLE_BITS-1:0] owner_q,
	output logic [31:0]            period_q,
	output logic [31:0]            count_q,
	output logic                   periodic_q
);

	// one timer slot; takes its neighbor's slot on every step of a walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q    <= '0;
			period_q   <= '0;
			count_q    <= '0;
			periodic_q <= 1'b0;
		end else if (shift) begin
			owner_q    <= owner_d;
			period_q   <= period_d;
			count_q    <= count_d;
			periodic_q <= periodic_d;
		end
	end

endmodule

/* hw/rtl/mss_head.sv */
module mss_head #(
	parameter int HANDLE_BITS = 16
) (
	input  logic [2:0]             op,
	input  logic [HANDLE_BITS-1:0] hnd,
	input  logic [31:0]            secs,
	input  logic                   found,
	input  logic [HANDLE_BITS-1:0] owner_i,
	input  logic [31:0]            period_i,
	input  logic [31:0]            count_i,
	input  logic                   periodic_i,
	output logic [HANDLE_BITS-1:0] owner_o,
	output logic [31:0]            period_o,
	output logic [31:0]            count_o,
	output logic                   periodic_o,
	output mss_pkg::head_res_t     res
);

	logic [31:0] count_dec;

	assign count_dec = count_i - 32'd1;

	always_comb begin
		owner_o    = owner_i;
		period_o   = period_i;
		count_o    = count_i;
		periodic_o = periodic_i;
		res        = '0;
		case (op)
			mss_pkg::OP_START_ONESHOT, mss_pkg::OP_START_PERIODIC: begin
				if (!found && owner_i == '0) begin
					res.match  = 1'b1;
					owner_o    = hnd;
					period_o   = secs;
					count_o    = secs;
					periodic_o = (op == mss_pkg::OP_START_PERIODIC);
				end
			end
			mss_pkg::OP_STOP: begin
				if (!found && owner_i == hnd) begin
					res.match = 1'b1;
					owner_o   = '0;
					count_o   = '0;
				end
			end
			mss_pkg::OP_RESTART: begin
				if (!found && owner_i == hnd) begin
					res.match = 1'b1;
					count_o   = period_i;
				end
			end
			mss_pkg::OP_TICK: begin
				if (count_i != '0) begin
					count_o = count_dec;
					if (count_dec == '0) begin
						res.expire = 1'b1;
						if (periodic_i) begin
							count_o = period_i;
						end else begin
							owner_o = '0;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* hw/rtl/multi_slot_software_timer.sv */
// Timer bank of NUM_SLOTS countdown slots held in a ring of cells. Every command or tick walks
// the ring once, one slot per cycle through a single head unit unless the walk stalls; an item
// passes through the accepting cycle, the walk, and a step to post its last result before the
// next transfer on cmd. The walk stalls on a second expiry, and the last result waits, whenever
// rsp_ready held low keeps a waiting result in the output register, be it an earlier expiry of
// a tick or the final result of an item. cmd_ready is high only between items.
// A tick gives one result per expired slot in ascending slot order, or one empty result; a
// command gives one status result.
module multi_slot_software_timer #(
	parameter int NUM_SLOTS   = 10,
	parameter int HANDLE_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  mss_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mss_pkg::rsp_t rsp
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [HANDLE_BITS-1:0] own_q [NUM_SLOTS];
	logic [31:0]            per_q [NUM_SLOTS];
	logic [31:0]            cnt_q [NUM_SLOTS];
	logic                   prd_q [NUM_SLOTS];

	logic [HANDLE_BITS-1:0] own_n;
	logic [31:0]            per_n;
	logic [31:0]            cnt_n;
	logic                   prd_n;
	mss_pkg::head_res_t     hres;

	mss_pkg::state_t state_q, state_d;
	mss_pkg::cmd_t   cmd_q;
	logic [IW-1:0]   step_q;
	logic            found_q;
	logic [3:0]      found_idx_q;
	logic            pend_valid_q;
	logic [15:0]     pend_handle_q;
	logic [3:0]      pend_idx_q;
	mss_pkg::rsp_t   rsp_q;
	logic            rsp_valid_q;

	logic        shift;
	logic        out_free;
	logic        push_pend;
	logic        post_final;
	logic [31:0] hnd32;
	logic [31:0] own32;
	logic [31:0] step32;
	logic [HANDLE_BITS-1:0] hnd_m;
	logic [15:0] fire_h;
	logic [3:0]  step4;

	assign hnd32  = 32'(cmd_q.handle);
	assign hnd_m  = hnd32[HANDLE_BITS-1:0];
	assign own32  = 32'(own_q[0]);
	assign fire_h = own32[15:0];
	assign step32 = 32'(step_q);
	assign step4  = step32[3:0];

	assign out_free = !rsp_valid_q || rsp_ready;

	mss_head #(.HANDLE_BITS(HANDLE_BITS)) u_head (
		.op         (cmd_q.op),
		.hnd        (hnd_m),
		.secs       (cmd_q.seconds),
		.found      (found_q),
		.owner_i    (own_q[0]),
		.period_i   (per_q[0]),
		.count_i    (cnt_q[0]),
		.periodic_i (prd_q[0]),
		.owner_o    (own_n),
		.period_o   (per_n),
		.count_o    (cnt_n),
		.periodic_o (prd_n),
		.res        (hres)
	);

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		if (i == NUM_SLOTS - 1) begin : g_tail
			mss_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.shift      (shift),
				.owner_d    (own_n),
				.period_d   (per_n),
				.count_d    (cnt_n),
				.periodic_d (prd_n),
				.owner_q    (own_q[i]),
				.period_q   (per_q[i]),
				.count_q    (cnt_q[i]),
				.periodic_q (prd_q[i])
			);
		end else begin : g_mid
			mss_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.shift      (shift),
				.owner_d    (own_q[i+1]),
				.period_d   (per_q[i+1]),
				.count_d    (cnt_q[i+1]),
				.periodic_d (prd_q[i+1]),
				.owner_q    (own_q[i]),
				.period_q   (per_q[i]),
				.count_q    (cnt_q[i]),
				.periodic_q (prd_q[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd_ready  = 1'b0;
		shift      = 1'b0;
		push_pend  = 1'b0;
		post_final = 1'b0;
		case (state_q)
			mss_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = mss_pkg::ST_WALK;
				end
			end
			mss_pkg::ST_WALK: begin
				// a second expiry needs the output register to take the pending one
				if (!(hres.expire && pend_valid_q && !out_free)) begin
					shift     = 1'b1;
					push_pend = hres.expire;
					if (step_q == IW'(NUM_SLOTS - 1)) begin
						state_d = mss_pkg::ST_FINISH;
					end
				end
			end
			mss_pkg::ST_FINISH: begin
				if (out_free) begin
					post_final = 1'b1;
					state_d    = mss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				step_q       <= '0;
				found_q      <= 1'b0;
				pend_valid_q <= 1'b0;
			end else if (shift) begin
				step_q <= step_q + IW'(1);
				if (hres.match) begin
					found_q <= 1'b1;
				end
				if (push_pend) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (post_final || (push_pend && pend_valid_q)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
		end
		if (shift && hres.match) begin
			found_idx_q <= step4;
		end
		if (push_pend) begin
			pend_handle_q <= fire_h;
			pend_idx_q    <= step4;
		end
		if (push_pend && pend_valid_q) begin
			rsp_q.kind         <= mss_pkg::KIND_EXPIRY;
			rsp_q.ok           <= 1'b1;
			rsp_q.fired_handle <= pend_handle_q;
			rsp_q.slot_index   <= pend_idx_q;
			rsp_q.last         <= 1'b0;
		end else if (post_final) begin
			rsp_q.last <= 1'b1;
			if (cmd_q.op == mss_pkg::OP_TICK) begin
				rsp_q.kind         <= mss_pkg::KIND_EXPIRY;
				rsp_q.ok           <= pend_valid_q;
				rsp_q.fired_handle <= pend_valid_q ? pend_handle_q : 16'd0;
				rsp_q.slot_index   <= pend_valid_q ? pend_idx_q : 4'd0;
			end else begin
				rsp_q.kind         <= mss_pkg::KIND_STATUS;
				rsp_q.ok           <= found_q;
				rsp_q.fired_handle <= 16'd0;
				rsp_q.slot_index   <= found_q ? found_idx_q : 4'd0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hw/rtl/mss_checker.sv */
module mss_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input mss_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input mss_pkg::rsp_t rsp
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one item at a time: no transfer in the cycle after an accepted one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("input ready right after a transfer");

	// a command gives a single status result with no handle
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == mss_pkg::KIND_STATUS |-> rsp.last && rsp.fired_handle == 16'd0)
		else $error("malformed status result");

	// failed lookups and empty ticks report slot zero
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> rsp.slot_index == 4'd0 && rsp.fired_handle == 16'd0 && rsp.last)
		else $error("malformed empty result");

endmodule

bind multi_slot_software_timer mss_checker u_mss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
